// ===== src/osf_pkg.sv =====
package osf_pkg;

    localparam int TRAIL_PAD_BYTES = 6;
    localparam int MAX_LENGTH = 4095;

    localparam logic REG_RATE_INDEX = 1'b0;
    localparam logic REG_PSDU_LENGTH = 1'b1;

    // Slots of one command in the back end: five header words, the payload
    // word, then the pad words.
    localparam int SLOT_PAYLOAD = 5;
    localparam int SLOT_LAST = SLOT_PAYLOAD + TRAIL_PAD_BYTES;
    localparam int SLOT_W = $clog2(SLOT_LAST + 1);

    localparam logic [7:0] ZERO_WORD = 8'h80;

    typedef struct packed {
        logic        first;
        logic        last;
        logic [7:0]  data;
        logic [7:0]  hdr0;
        logic [7:0]  hdr1;
        logic [7:0]  hdr2;
        logic [3:0]  rate;
        logic [15:0] frame_bits;
    } cmd_t;

    function automatic logic [3:0] rate_code(input logic [2:0] idx);
        logic [3:0] rc;
        unique case (idx)
            3'd0: rc = 4'd13;
            3'd1: rc = 4'd15;
            3'd2: rc = 4'd5;
            3'd3: rc = 4'd7;
            3'd4: rc = 4'd9;
            3'd5: rc = 4'd11;
            3'd6: rc = 4'd1;
            default: rc = 4'd3;
        endcase
        return rc;
    endfunction

    function automatic logic [7:0] ndbps(input logic [2:0] idx);
        logic [7:0] n;
        unique case (idx)
            3'd0: n = 8'd24;
            3'd1: n = 8'd36;
            3'd2: n = 8'd48;
            3'd3: n = 8'd72;
            3'd4: n = 8'd96;
            3'd5: n = 8'd144;
            3'd6: n = 8'd192;
            default: n = 8'd216;
        endcase
        return n;
    endfunction

endpackage

// ===== src/osf_front.sv =====
module osf_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          in_data,
    input  logic [2:0]          rate_index,
    input  logic [11:0]         psdu_length,
    output logic                q_push,
    output osf_pkg::cmd_t       q_data,
    input  logic                q_full
);

    typedef enum logic [2:0]
    {
        F_IDLE  = 3'b001,
        F_DIV   = 3'b010,
        F_ISSUE = 3'b100
    } fstate_t;

    fstate_t        state_reg, state_next;
    logic [11:0]    pos_reg, pos_next;
    logic [15:0]    total_reg, total_next;
    osf_pkg::cmd_t  cmd_reg, cmd_next;
    logic [15:0]    n_reg, n_next;
    logic [15:0]    num_reg, num_next;
    logic [7:0]     rem_reg, rem_next;
    logic [7:0]     div_reg, div_next;
    logic [3:0]     cnt_reg, cnt_next;

    logic [11:0]    eff_len;
    logic [3:0]     rc;
    logic           par;
    logic           first;
    logic           last_now;
    logic           accept;
    logic [8:0]     trial;
    logic [15:0]    bits;

    always_comb
    begin
        if (psdu_length == 12'd0)
            eff_len = 12'd1;
        else if ({20'd0, psdu_length} > 32'(osf_pkg::MAX_LENGTH))
            eff_len = 12'(osf_pkg::MAX_LENGTH);
        else
            eff_len = psdu_length;
    end

    assign rc       = osf_pkg::rate_code(rate_index);
    assign par      = (^rc) ^ (^eff_len);
    assign first    = (pos_reg == 12'd0);
    assign last_now = ({1'b0, pos_reg} + 13'd1) >= {1'b0, eff_len};
    assign full     = !(state_reg == F_IDLE && !q_full);
    assign accept   = push && !full;
    assign trial    = {rem_reg, num_reg[15]};
    // Bits rounded up to whole symbols plus 24: N - (N mod NDBPS) + 24, N already biased up.
    assign bits     = 16'(n_reg + 16'd24 - {8'd0, rem_reg});

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        cmd_next   = cmd_reg;
        n_next     = n_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        q_push     = 1'b0;
        q_data     = cmd_reg;

        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    pos_next = last_now ? 12'd0 : 12'(pos_reg + 12'd1);
                    if (first)
                    begin
                        cmd_next.first      = 1'b1;
                        cmd_next.last       = last_now;
                        cmd_next.data       = in_data;
                        cmd_next.hdr0       = {eff_len[2:0], 1'b0, rc} ^ osf_pkg::ZERO_WORD;
                        cmd_next.hdr1       = eff_len[10:3] ^ osf_pkg::ZERO_WORD;
                        cmd_next.hdr2       = {6'd0, par, eff_len[11]} ^ osf_pkg::ZERO_WORD;
                        cmd_next.rate       = rc;
                        cmd_next.frame_bits = total_reg;
                        n_next   = 16'(16'd21 + {1'b0, eff_len, 3'b000}
                                       + {8'd0, osf_pkg::ndbps(rate_index)});
                        num_next = 16'(16'd21 + {1'b0, eff_len, 3'b000}
                                       + {8'd0, osf_pkg::ndbps(rate_index)});
                        rem_next = 8'd0;
                        div_next = osf_pkg::ndbps(rate_index);
                        cnt_next = 4'd0;
                        state_next = F_DIV;
                    end
                    else
                    begin
                        q_push              = 1'b1;
                        q_data.first        = 1'b0;
                        q_data.last         = last_now;
                        q_data.data         = in_data;
                        q_data.rate         = rc;
                        q_data.frame_bits   = total_reg;
                    end
                end
            end
            F_DIV:
            begin
                if (trial >= {1'b0, div_reg})
                    rem_next = 8'(trial - {1'b0, div_reg});
                else
                    rem_next = trial[7:0];
                num_next = {num_reg[14:0], 1'b0};
                cnt_next = 4'(cnt_reg + 4'd1);
                if (cnt_reg == 4'd15)
                    state_next = F_ISSUE;
            end
            F_ISSUE:
            begin
                q_data.frame_bits = bits;
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    total_next = bits;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            pos_reg   <= 12'd0;
            total_reg <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        n_reg   <= n_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
    end

endmodule

// ===== src/osf_queue.sv =====
module osf_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  osf_pkg::cmd_t   wdata,
    output logic            full,
    input  logic            pop,
    output osf_pkg::cmd_t   rdata,
    output logic            empty
);

    osf_pkg::cmd_t  mem_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = do_push ? !wptr_reg : wptr_reg;
        rptr_next  = do_pop ? !rptr_reg : rptr_reg;
        count_next = 2'(count_reg + {1'b0, do_push} - {1'b0, do_pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= wdata;
    end

endmodule

// ===== src/osf_back.sv =====
module osf_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  osf_pkg::cmd_t       q_data,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          word,
    output logic                last_word,
    output logic [3:0]          rate,
    output logic [15:0]         frame_bits
);

    localparam logic [osf_pkg::SLOT_W-1:0] SLOT_PAY =
        osf_pkg::SLOT_W'(osf_pkg::SLOT_PAYLOAD);
    localparam logic [osf_pkg::SLOT_W-1:0] SLOT_END =
        osf_pkg::SLOT_W'(osf_pkg::SLOT_LAST);

    osf_pkg::cmd_t                  cur_reg, cur_next;
    logic                           busy_reg, busy_next;
    logic [osf_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [osf_pkg::SLOT_W-1:0]     end_slot;
    logic                           at_end;
    logic                           take;

    assign end_slot = cur_reg.last ? SLOT_END : SLOT_PAY;
    assign at_end   = (slot_reg == end_slot);
    assign empty    = !busy_reg;
    assign take     = !q_empty && (!busy_reg || (pop && at_end));
    assign q_pop    = take;

    always_comb
    begin
        busy_next = busy_reg;
        slot_next = slot_reg;
        cur_next  = cur_reg;
        if (take)
        begin
            busy_next = 1'b1;
            cur_next  = q_data;
            slot_next = q_data.first ? '0 : SLOT_PAY;
        end
        else if (busy_reg && pop)
        begin
            if (at_end)
                busy_next = 1'b0;
            else
                slot_next = osf_pkg::SLOT_W'(slot_reg + 1'b1);
        end
    end

    always_comb
    begin
        case (slot_reg)
            osf_pkg::SLOT_W'(0): word = cur_reg.hdr0;
            osf_pkg::SLOT_W'(1): word = cur_reg.hdr1;
            osf_pkg::SLOT_W'(2): word = cur_reg.hdr2;
            SLOT_PAY:            word = cur_reg.data;
            default:             word = osf_pkg::ZERO_WORD;
        endcase
    end

    assign last_word  = cur_reg.last && (slot_reg == SLOT_END);
    assign rate       = cur_reg.rate;
    assign frame_bits = cur_reg.frame_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

// ===== src/ofdm_signal_header_framer.sv =====
// Frames PSDU bytes into an 802.11a data unit: three SIGNAL words, two zero
// SERVICE words, the payload words, then the trailing zero pad words.
// Input side: a queue write port. A byte is taken at a clock edge where push
// is high and full is low. Output side: a queue read port. The oldest word
// sits on out_byte, last_of_packet, rate_value and frame_bits while empty is
// low, and is taken at an edge where pop is high.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while the
// block is idle: index 0 is the rate index, index 1 the PSDU length.
// Throughput: a byte inside a packet passes the front end straight into the
// command queue, so payload runs at one word per cycle while pop is high.
// The first byte holds the front end while the 16-step restoring divider
// rounds the bit count up to whole symbols. The back end emits one word per
// cycle while pop is high: six for the first byte, one for a middle byte,
// and seven more for the last byte. A two-entry command queue lets the front
// end divide while the back end still streams the previous packet's pad.
// Reset returns both configuration registers to their defaults, clears the
// byte position and bit count, and empties all queues. When the receiver
// stalls, the output word holds, the command queue fills, and full rises.
module ofdm_signal_header_framer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [7:0]   psdu_byte,
    output logic                empty,
    input  logic                pop,
    output logic signed [7:0]   out_byte,
    output logic                last_of_packet,
    output logic [3:0]          rate_value,
    output logic [15:0]         frame_bits,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [11:0]         cfg_wdata
);

    logic [2:0]     rate_index_reg, rate_index_next;
    logic [11:0]    psdu_length_reg, psdu_length_next;

    osf_pkg::cmd_t  fq_data;
    logic           fq_push;
    logic           fq_full;
    osf_pkg::cmd_t  bq_data;
    logic           bq_empty;
    logic           bq_pop;
    logic [7:0]     word;

    // Configuration registers.
    always_comb
    begin
        rate_index_next  = rate_index_reg;
        psdu_length_next = psdu_length_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                osf_pkg::REG_RATE_INDEX:  rate_index_next  = cfg_wdata[2:0];
                osf_pkg::REG_PSDU_LENGTH: psdu_length_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_index_reg  <= 3'd0;
            psdu_length_reg <= 12'd1504;
        end
        else
        begin
            rate_index_reg  <= rate_index_next;
            psdu_length_reg <= psdu_length_next;
        end
    end

    // The front end classifies each byte and works out the header.
    osf_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_data     ($unsigned(psdu_byte)),
        .rate_index  (rate_index_reg),
        .psdu_length (psdu_length_reg),
        .q_push      (fq_push),
        .q_data      (fq_data),
        .q_full      (fq_full)
    );

    osf_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata (fq_data),
        .full  (fq_full),
        .pop   (bq_pop),
        .rdata (bq_data),
        .empty (bq_empty)
    );

    // The back end expands each command into its output words.
    osf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (bq_data),
        .q_empty    (bq_empty),
        .q_pop      (bq_pop),
        .empty      (empty),
        .pop        (pop),
        .word       (word),
        .last_word  (last_of_packet),
        .rate       (rate_value),
        .frame_bits (frame_bits)
    );

    assign out_byte = $signed(word);

endmodule
